FILE: rtl/dsfd_pkg.sv
package dsfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIN_DEPTH  = 6;
    localparam int RAW_W      = 16;
    localparam int MV_W       = 18;
    localparam int DENS_W     = 16;
    localparam int COEF_W     = 12;
    localparam int NUM_RANGES = 14;

    // raw * 625 needs 16 + 10 bits
    localparam int MV_PROD_W  = RAW_W + 10;
    localparam int MV_SHIFT   = 8;
    localparam logic [MV_PROD_W-1:0] MV_SCALE = MV_PROD_W'(625);

    // raw * coef, then * 5 and >> 11
    localparam int DPROD_W    = RAW_W + COEF_W;
    localparam int DX5_W      = DPROD_W + 3;
    localparam int DENS_SHIFT = 11;
    localparam int DQ_W       = DX5_W - DENS_SHIFT;
    localparam logic [DENS_W-1:0] DENS_MAX = '1;

    localparam logic [BYTE_W-1:0] START_MARK = 8'hAA;
    localparam logic [BYTE_W-1:0] STOP_MARK  = 8'hFF;

    localparam logic [COEF_W-1:0] COEF_TABLE [NUM_RANGES] = '{
        12'd200,  12'd400,  12'd600,  12'd750,  12'd900,  12'd1000, 12'd1250,
        12'd1400, 12'd1700, 12'd1800, 12'd1900, 12'd2000, 12'd2200, 12'd3000
    };

    // inclusive upper bound of each range except the last
    localparam logic [BYTE_W-1:0] RANGE_TOP [NUM_RANGES-1] = '{
        8'd45, 8'd48, 8'd51, 8'd54, 8'd58, 8'd64, 8'd70,
        8'd75, 8'd80, 8'd85, 8'd90, 8'd100, 8'd110
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MV,
        S_DENS,
        S_SAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic load_mv;
        logic load_prod;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_hit;
    } t_dp_stat;

    // first matching range wins
    function automatic logic [COEF_W-1:0] coef_lookup(input logic [BYTE_W-1:0] v);
        logic [COEF_W-1:0] c;
        c = COEF_TABLE[NUM_RANGES-1];
        for (int k = NUM_RANGES - 2; k >= 0; k--) begin
            if (v <= RANGE_TOP[k]) begin
                c = COEF_TABLE[k];
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/dsfd_if.sv
interface dsfd_in_if;
    import dsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dsfd_out_if;
    import dsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic              frame_ok;
    logic [DENS_W-1:0] density;
    logic [MV_W-1:0]   millivolts;

    modport source (output valid, output frame_ok, output density, output millivolts,
                    input ready);
    modport sink   (input valid, input frame_ok, input density, input millivolts,
                    output ready);
endinterface

FILE: rtl/dsfd_dp.sv
module dsfd_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dsfd_pkg::t_dp_cmd         i_cmd,
    output dsfd_pkg::t_dp_stat        o_stat,
    input  logic [dsfd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                      o_frame_ok,
    output logic [dsfd_pkg::DENS_W-1:0] o_density,
    output logic [dsfd_pkg::MV_W-1:0] o_millivolts
);
    import dsfd_pkg::*;

    logic [BYTE_W-1:0]    r_win [WIN_DEPTH];
    logic [RAW_W-1:0]     r_raw;
    logic                 r_sum_ok;
    logic [MV_W-1:0]      r_mv;
    logic [DPROD_W-1:0]   r_prod;
    logic                 r_ok;
    logic [DENS_W-1:0]    r_dens;
    logic [MV_W-1:0]      r_mv_out;

    logic [BYTE_W-1:0]    n_sum;
    logic [MV_PROD_W-1:0] n_mv_prod;
    logic [DPROD_W-1:0]   n_prod;
    logic [DX5_W-1:0]     n_x5;
    logic [DQ_W-1:0]      n_q;
    logic [DENS_W-1:0]    n_dens;

    assign o_stat.frame_hit = (i_rx_byte == STOP_MARK) && (r_win[0] == START_MARK);

    always_comb begin
        n_sum     = r_win[1] + r_win[2] + r_win[3] + r_win[4];
        n_mv_prod = MV_PROD_W'(r_raw) * MV_SCALE;
        n_prod    = DPROD_W'(r_raw) * DPROD_W'(coef_lookup(r_mv[BYTE_W-1:0]));
        n_x5      = DX5_W'(r_prod) + {1'b0, r_prod, 2'b00};
        n_q       = n_x5[DX5_W-1:DENS_SHIFT];
        n_dens    = (n_q > DQ_W'(DENS_MAX)) ? DENS_MAX : n_q[DENS_W-1:0];
    end

    // byte window, oldest in entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WIN_DEPTH-1] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_raw    <= {r_win[1], r_win[2]};
            r_sum_ok <= (n_sum == r_win[5]);
        end
        if (i_cmd.load_mv) begin
            r_mv <= n_mv_prod[MV_SHIFT +: MV_W];
        end
        if (i_cmd.load_prod) begin
            r_prod <= n_prod;
        end
        if (i_cmd.load_out) begin
            r_ok     <= r_sum_ok;
            r_dens   <= r_sum_ok ? n_dens : '0;
            r_mv_out <= r_sum_ok ? r_mv : '0;
        end
    end

    assign o_frame_ok   = r_ok;
    assign o_density    = r_dens;
    assign o_millivolts = r_mv_out;

endmodule

FILE: rtl/dsfd_ctrl.sv
module dsfd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dsfd_pkg::t_dp_stat  i_stat,
    output dsfd_pkg::t_dp_cmd   o_cmd
);
    import dsfd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd           = '0;
        in_xfer         = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                in_xfer    = i_in_valid;
                o_cmd.shift = in_xfer;
                if (in_xfer && i_stat.frame_hit) begin
                    n_state = S_MV;
                end
            end
            S_MV: begin
                o_cmd.load_mv = 1'b1;
                n_state       = S_DENS;
            end
            S_DENS: begin
                o_cmd.load_prod = 1'b1;
                n_state         = S_SAT;
            end
            S_SAT: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_hit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_stat.frame_hit) |=> (r_state == S_MV))
        else $error("frame completion did not start the computation");

    a_miss_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_stat.frame_hit) |=> (r_state == S_IDLE))
        else $error("non-frame byte left idle");

    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

    a_no_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |-> (o_in_ready && !o_out_valid))
        else $error("window shifted while busy");

endmodule

FILE: rtl/dust_sensor_frame_density.sv
// Dust sensor frame decoder.
//
// i_in carries one received UART byte per transfer (rx_byte). The block keeps
// the last six bytes; when a 0xFF byte arrives and the byte six places earlier
// is 0xAA, the seven bytes form a frame and one result goes out on o_out:
// frame_ok, density and millivolts. Rejected frames (checksum mismatch) give
// frame_ok = 0 with zero density and millivolts. Other bytes give no result.
//
// Timing: a byte that completes no frame leaves the controller idle, ready for
// the next byte. A frame byte is followed by the compute steps (millivolt
// multiply, coefficient multiply, scale and saturate) in states S_MV, S_DENS and
// S_SAT; then the result sits in the output register and valid rises in S_OUT.
// The input is held off (ready low) from the frame byte's transfer until the
// result is taken, and the next byte is accepted after that.
//
// A stalled receiver holds the result and the input stays blocked until the
// result transfer. Reset (synchronous, active low) clears the window to zeros
// and returns the controller to idle; no frame completes before six bytes.
module dust_sensor_frame_density (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsfd_in_if.sink     i_in,
    dsfd_out_if.source  o_out
);
    import dsfd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    // sequence the decode: shift, two multiplies, saturate, hand off
    dsfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // byte window, frame check and fixed-point arithmetic
    dsfd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_rx_byte    (i_in.rx_byte),
        .o_frame_ok   (o_out.frame_ok),
        .o_density    (o_out.density),
        .o_millivolts (o_out.millivolts)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // a rejected frame must carry zero payload
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_out.frame_ok) |-> (o_out.density == '0 && o_out.millivolts == '0))
        else $error("rejected frame with nonzero payload");

    // the input side stays closed while a result waits
    a_block_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input open while result pending");

endmodule
